/* rtl/core/array_linked_list_engine_defines.svh */
// Assertion macros shared by the linked list engine RTL.
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH

// condition holds at every clock edge outside reset
`define ALLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define ALLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define ALLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* rtl/core/alle_pkg.sv */
// Types and constants of the linked list engine.
package alle_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD   = 3'd0,
        ACT_INS_AFTER  = 3'd1,
        ACT_DEL_AFTER  = 3'd2,
        ACT_WALK_FIRST = 3'd3,
        ACT_WALK_NEXT  = 3'd4
    } t_action;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      at_end;
        logic [STATUS_W-1:0]       status;
    } t_result;

endpackage

/* rtl/core/alle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read (read-first).
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/alle_out_buf.sv */
// Output register of the result channel; frees the core while a result waits.
module alle_out_buf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  alle_pkg::t_result                   i_res,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [alle_pkg::VALUE_W-1:0] o_read_value,
    output logic                                o_at_end,
    output logic [alle_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_free
);
    import alle_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free       = !r_valid || i_out_ready;
    assign o_out_valid  = r_valid;
    assign o_read_value = r_res.read_value;
    assign o_at_end     = r_res.at_end;
    assign o_status     = r_res.status;

endmodule

/* rtl/core/array_linked_list_engine.sv */
// Linked list engine: node pool in value and link RAMs, list control FSM.
//
// Input channel (i_in_valid / o_in_ready) takes one action item: i_action,
// i_item_value, i_position. Output channel (o_out_valid / i_out_ready) gives
// exactly one result item per action: o_read_value, o_at_end, o_status.
// One action is in progress at a time. How each result is formed:
//   in the idle state - insert at head, refused inserts, position out of
//       range, walk at list end, unused action codes
//   after one link read - insert after k, delete head, walk that reads a
//       node, delete after k whose k-th node has no successor
//   after two dependent link reads, then a link write - delete after k
// The RAM reads are registered; the next item is taken in the cycle after
// the result is registered.
// A result waiting in the output register does not hold up the next item;
// only when that item's own result is ready and the receiver still stalls
// does the core wait, and then it accepts nothing further.
// Reset empties the list, clears the insert count and the walk cursor; the
// node RAMs are not cleared and need no clearing pass.
`include "array_linked_list_engine_defines.svh"

module array_linked_list_engine #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [alle_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [alle_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [alle_pkg::POS_W-1:0]           i_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [alle_pkg::VALUE_W-1:0]  o_read_value,
    output logic                                 o_at_end,
    output logic [alle_pkg::STATUS_W-1:0]        o_status
);
    import alle_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int IW = $clog2(POOL_DEPTH + 1);
    localparam int CW = (IW > POS_W) ? IW : POS_W;
    localparam logic [IW-1:0] NULL_IDX = IW'(POOL_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_LINK,
        S_DEL_HEAD,
        S_DEL_NXT,
        S_DEL_WR,
        S_WALK,
        S_HOLD
    } t_state;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_used, n_used;
    logic [IW-1:0]        r_cursor, n_cursor;
    logic [AW-1:0]        r_slot, n_slot;
    logic [VALUE_W-1:0]   r_value, n_value;
    t_result              r_res, n_res;

    logic                 link_we, link_re, val_we, val_re;
    logic [AW-1:0]        link_waddr, link_raddr, val_waddr, val_raddr;
    logic [IW-1:0]        link_wdata, link_rdata;
    logic [VALUE_W-1:0]   val_wdata, val_rdata;

    logic                 in_acc, out_free, out_load, res_valid;
    t_result              res, out_res;
    logic [CW-1:0]        k_ext, k_m1, used_ext;
    logic [AW-1:0]        ref_slot;
    logic                 pool_full;
    logic [IW-1:0]        walk_cur;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign k_ext      = CW'(i_position);
    assign k_m1       = k_ext - CW'(1);
    assign used_ext   = CW'(r_used);
    assign ref_slot   = k_m1[AW-1:0];
    assign pool_full  = (r_used >= NULL_IDX);
    assign walk_cur   = (i_action == ACT_WALK_FIRST) ? r_head : r_cursor;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_used     = r_used;
        n_cursor   = r_cursor;
        n_slot     = r_slot;
        n_value    = r_value;
        n_res      = r_res;
        link_we    = 1'b0;
        link_waddr = r_slot;
        link_wdata = link_rdata;
        link_re    = 1'b0;
        link_raddr = r_slot;
        val_we     = 1'b0;
        val_waddr  = r_slot;
        val_wdata  = r_value;
        val_re     = 1'b0;
        val_raddr  = r_slot;
        res_valid  = 1'b0;
        res        = '0;
        out_load   = 1'b0;
        out_res    = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_action)
                        ACT_INS_HEAD: begin
                            res_valid = 1'b1;
                            if (pool_full) begin
                                res.status = ST_FULL;
                            end else begin
                                val_we     = 1'b1;
                                val_waddr  = r_used[AW-1:0];
                                val_wdata  = i_item_value;
                                link_we    = 1'b1;
                                link_waddr = r_used[AW-1:0];
                                link_wdata = r_head;
                                n_head     = r_used;
                                n_used     = r_used + IW'(1);
                            end
                        end
                        ACT_INS_AFTER: begin
                            if (i_position == '0 || k_ext > used_ext) begin
                                res_valid  = 1'b1;
                                res.status = ST_BAD_POS;
                            end else if (pool_full) begin
                                res_valid  = 1'b1;
                                res.status = ST_FULL;
                            end else begin
                                // read-first RAM: old link comes back, new one lands
                                link_re    = 1'b1;
                                link_raddr = ref_slot;
                                link_we    = 1'b1;
                                link_waddr = ref_slot;
                                link_wdata = r_used;
                                n_slot     = r_used[AW-1:0];
                                n_value    = i_item_value;
                                n_used     = r_used + IW'(1);
                                n_state    = S_INS_LINK;
                            end
                        end
                        ACT_DEL_AFTER: begin
                            if (i_position == '0) begin
                                if (r_head >= NULL_IDX) begin
                                    res_valid  = 1'b1;
                                    res.status = ST_BAD_POS;
                                end else begin
                                    link_re    = 1'b1;
                                    link_raddr = r_head[AW-1:0];
                                    n_state    = S_DEL_HEAD;
                                end
                            end else if (k_ext > used_ext) begin
                                res_valid  = 1'b1;
                                res.status = ST_BAD_POS;
                            end else begin
                                link_re    = 1'b1;
                                link_raddr = ref_slot;
                                n_slot     = ref_slot;
                                n_state    = S_DEL_NXT;
                            end
                        end
                        ACT_WALK_FIRST, ACT_WALK_NEXT: begin
                            if (walk_cur >= NULL_IDX) begin
                                n_cursor   = NULL_IDX;
                                res_valid  = 1'b1;
                                res.at_end = 1'b1;
                            end else begin
                                link_re    = 1'b1;
                                link_raddr = walk_cur[AW-1:0];
                                val_re     = 1'b1;
                                val_raddr  = walk_cur[AW-1:0];
                                n_state    = S_WALK;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_slot;
                link_wdata = link_rdata;
                val_we     = 1'b1;
                val_waddr  = r_slot;
                val_wdata  = r_value;
                res_valid  = 1'b1;
            end
            S_DEL_HEAD: begin
                n_head    = link_rdata;
                res_valid = 1'b1;
            end
            S_DEL_NXT: begin
                if (link_rdata >= NULL_IDX) begin
                    res_valid  = 1'b1;
                    res.status = ST_BAD_POS;
                end else begin
                    // chase the successor's link
                    link_re    = 1'b1;
                    link_raddr = link_rdata[AW-1:0];
                    n_state    = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                link_we    = 1'b1;
                link_waddr = r_slot;
                link_wdata = link_rdata;
                res_valid  = 1'b1;
            end
            S_WALK: begin
                n_cursor       = link_rdata;
                res_valid      = 1'b1;
                res.read_value = val_rdata;
            end
            S_HOLD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_valid) begin
            if (out_free) begin
                out_load = 1'b1;
                out_res  = res;
                n_state  = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NULL_IDX;
            r_used   <= '0;
            r_cursor <= NULL_IDX;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_used   <= n_used;
            r_cursor <= n_cursor;
        end
        r_slot  <= n_slot;
        r_value <= n_value;
        r_res   <= n_res;
    end

    alle_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    alle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    alle_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (out_load),
        .i_res        (out_res),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_read_value (o_read_value),
        .o_at_end     (o_at_end),
        .o_status     (o_status),
        .o_free       (out_free)
    );

    `ALLE_ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= NULL_IDX)
    `ALLE_ASSERT_NEXT(a_used_step, i_clk, i_rst_n, 1'b1, (r_used - $past(r_used)) <= IW'(1))
    `ALLE_ASSERT_ALWAYS(a_ptr_range, i_clk, i_rst_n, (r_head <= NULL_IDX) && (r_cursor <= NULL_IDX))
    `ALLE_ASSERT_IMPL(a_link_wr_slot, i_clk, i_rst_n, link_we, IW'(link_waddr) <= r_used)

endmodule
